FILE: hdl/s5ch_pkg.sv
// Package for the SOCKS5 client handshake unit: protocol byte values, input kind
// codes, status codes, register indexes and the controller/datapath interface types.
// Has no dependencies; every other file refers to it by scoped names.
package s5ch_pkg;

	localparam int NAME_DEPTH_DEF = 256;

	// Input item kinds.
	localparam logic [1:0] KIND_EMPTY = 2'd0;
	localparam logic [1:0] KIND_BYTE  = 2'd1;
	localparam logic [1:0] KIND_NAME  = 2'd2;

	// Result status codes.
	localparam logic [2:0] ST_NEED       = 3'd0;
	localparam logic [2:0] ST_DONE       = 3'd1;
	localparam logic [2:0] ST_UNEXPECTED = 3'd2;
	localparam logic [2:0] ST_AUTH       = 3'd3;
	localparam logic [2:0] ST_CONNECT    = 3'd4;

	// Configuration register indexes.
	localparam logic REG_REMOTE_PORT = 1'b0;
	localparam logic REG_NAME_LENGTH = 1'b1;

	// Protocol byte values.
	localparam logic [7:0] SOCKS_VER     = 8'h05;
	localparam logic [7:0] CMD_CONNECT   = 8'h01;
	localparam logic [7:0] RSV_BYTE      = 8'h00;
	localparam logic [7:0] ATYP_IPV4     = 8'h01;
	localparam logic [7:0] ATYP_DOMAIN   = 8'h03;
	localparam logic [7:0] ATYP_IPV6     = 8'h04;
	localparam logic [7:0] METHOD_NONE   = 8'h00;
	localparam logic [7:0] METHOD_REJECT = 8'hFF;
	localparam logic [7:0] REPLY_OK      = 8'h00;
	localparam logic [7:0] NMETHODS_ONE  = 8'h01;

	localparam logic [3:0] PKT_LEN_MAX = 4'd15;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       take_byte;
		logic       clear_pkt;
		logic       store_wr;
		logic       load_greet;
		logic       load_status;
		logic [2:0] load_st;
		logic       start_emit;
		logic       emit_run;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic       out_free;
		logic [2:0] meth_st;
		logic [2:0] reply_st;
		logic       word_done;
		logic       msg_last;
	} dp_stat_t;

endpackage

FILE: hdl/socks5_client_handshake_unit.sv
// Top level of the SOCKS5 client handshake unit (no authentication, CONNECT by
// domain name). Depends on s5ch_pkg, s5ch_ctrl, s5ch_datapath and s5ch_ram.
//
// Usage: each input transaction is a received byte (kind 1, packet_end marks
// the last byte of a packet), an empty packet end (kind 0), or a write of one
// domain name byte into the name store (kind 2). Before starting, write the
// name bytes and the two configuration registers (remote port, name length)
// through the cfg_we/cfg_index/cfg_data port while the unit is idle.
// Each packet end yields result transactions on the output channel: the
// greeting 05 01 00, a status after each reply check, or the CONNECT request
// split into runs of up to eight bytes, the final run marked by run_last.
// A greeting or status result appears in the output register on the cycle
// following the input that closes its packet, so the unit sustains one input
// per cycle while the receiver keeps up and no request is emitted. The CONNECT
// request, 7 + name_length bytes, is assembled one byte per cycle, since the
// name store has one read port, and stalls on a busy output register; input
// is not accepted. Reset clears the configuration, the protocol phase and the
// packet capture; the name store holds no reset value and must be written
// before use. When the receiver stalls, the finished result is held and no new
// input is taken until the output register can be reloaded.
module socks5_client_handshake_unit #(
	parameter int NAME_DEPTH = s5ch_pkg::NAME_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  kind,
	input  logic [7:0]  data_byte,
	input  logic        packet_end,
	input  logic [7:0]  name_index,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] tx_bytes,
	output logic [3:0]  tx_count,
	output logic [2:0]  status,
	output logic        run_last
);

	s5ch_pkg::dp_cmd_t  cmd;
	s5ch_pkg::dp_stat_t stat;

	// The controller owns the protocol phase and decides what each transaction does.
	s5ch_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.kind       (kind),
		.packet_end (packet_end),
		.stat       (stat),
		.cmd        (cmd)
	);

	// The datapath captures packets, checks replies and builds every result.
	s5ch_datapath #(
		.NAME_DEPTH(NAME_DEPTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.data_byte  (data_byte),
		.name_index (name_index),
		.cmd        (cmd),
		.stat       (stat),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.tx_bytes   (tx_bytes),
		.tx_count   (tx_count),
		.status     (status),
		.run_last   (run_last)
	);

endmodule

FILE: hdl/s5ch_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module s5ch_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                       wr_data,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                       rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

FILE: hdl/s5ch_datapath.sv
// Datapath of the SOCKS5 client handshake unit: configuration registers, packet
// capture, reply checks, domain name store, request assembly and result register.
// Depends on s5ch_pkg and s5ch_ram.
module s5ch_datapath #(
	parameter int NAME_DEPTH = s5ch_pkg::NAME_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic [7:0]         data_byte,
	input  logic [7:0]         name_index,
	input  s5ch_pkg::dp_cmd_t  cmd,
	output s5ch_pkg::dp_stat_t stat,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [63:0]        tx_bytes,
	output logic [3:0]         tx_count,
	output logic [2:0]         status,
	output logic               run_last
);

	localparam int AW = (NAME_DEPTH > 1) ? $clog2(NAME_DEPTH) : 1;
	localparam logic [8:0] DEPTH9 = 9'(NAME_DEPTH);

	logic [15:0] remote_port_q;
	logic [7:0]  name_len_q;

	logic [3:0] pkt_len_q;
	logic [7:0] first_q, second_q, atype_q;
	logic       anz_q;

	logic [3:0] len_nx, len_eff;
	logic [7:0] first_nx, second_nx, atype_nx;
	logic       anz_nx;
	logic [7:0] first_eff, second_eff, atype_eff;
	logic       anz_eff;

	logic [8:0]  pos_q, pos_nx, total, nm_idx, nm_nx;
	logic [63:0] acc_q, word;
	logic [2:0]  lane;
	logic [7:0]  tx_b;
	logic        nm_ok, last_byte, word_done, advance, push;
	logic        store_en;
	logic [7:0]  rd_data;

	logic        out_valid_q;
	logic [63:0] tx_bytes_q;
	logic [3:0]  tx_count_q;
	logic [2:0]  status_q;
	logic        run_last_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			remote_port_q <= '0;
			name_len_q    <= '0;
		end else if (cfg_we) begin
			if (cfg_index == s5ch_pkg::REG_REMOTE_PORT) begin
				remote_port_q <= cfg_data;
			end else begin
				name_len_q <= cfg_data[7:0];
			end
		end
	end

	// Packet capture: values after taking the incoming byte.
	always_comb begin
		len_nx    = (pkt_len_q == s5ch_pkg::PKT_LEN_MAX) ? pkt_len_q : pkt_len_q + 4'd1;
		first_nx  = (pkt_len_q == 4'd0) ? data_byte : first_q;
		second_nx = (pkt_len_q == 4'd1) ? data_byte : second_q;
		atype_nx  = (pkt_len_q == 4'd3) ? data_byte : atype_q;
		anz_nx    = anz_q | ((pkt_len_q >= 4'd4) && (pkt_len_q <= 4'd9) && (data_byte != 8'h00));
		len_eff    = cmd.take_byte ? len_nx : pkt_len_q;
		first_eff  = cmd.take_byte ? first_nx : first_q;
		second_eff = cmd.take_byte ? second_nx : second_q;
		atype_eff  = cmd.take_byte ? atype_nx : atype_q;
		anz_eff    = cmd.take_byte ? anz_nx : anz_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pkt_len_q <= '0;
			first_q   <= '0;
			second_q  <= '0;
			atype_q   <= '0;
			anz_q     <= 1'b0;
		end else if (cmd.clear_pkt) begin
			pkt_len_q <= '0;
			first_q   <= '0;
			second_q  <= '0;
			atype_q   <= '0;
			anz_q     <= 1'b0;
		end else if (cmd.take_byte) begin
			pkt_len_q <= len_nx;
			first_q   <= first_nx;
			second_q  <= second_nx;
			atype_q   <= atype_nx;
			anz_q     <= anz_nx;
		end
	end

	// Verdicts on the packet as it stands once the current byte is counted.
	always_comb begin
		if ((len_eff != 4'd2) || (first_eff != s5ch_pkg::SOCKS_VER)) begin
			stat.meth_st = s5ch_pkg::ST_UNEXPECTED;
		end else if (second_eff == s5ch_pkg::METHOD_REJECT) begin
			stat.meth_st = s5ch_pkg::ST_AUTH;
		end else if (second_eff != s5ch_pkg::METHOD_NONE) begin
			stat.meth_st = s5ch_pkg::ST_UNEXPECTED;
		end else begin
			stat.meth_st = s5ch_pkg::ST_NEED;
		end

		if (len_eff < 4'd4) begin
			stat.reply_st = s5ch_pkg::ST_UNEXPECTED;
		end else if (second_eff != s5ch_pkg::REPLY_OK) begin
			stat.reply_st = s5ch_pkg::ST_CONNECT;
		end else if (atype_eff == s5ch_pkg::ATYP_IPV4) begin
			stat.reply_st = ((len_eff != 4'd10) || anz_eff) ? s5ch_pkg::ST_UNEXPECTED
			                                                : s5ch_pkg::ST_DONE;
		end else if ((atype_eff == s5ch_pkg::ATYP_DOMAIN) ||
		             (atype_eff == s5ch_pkg::ATYP_IPV6)) begin
			stat.reply_st = s5ch_pkg::ST_UNEXPECTED;
		end else begin
			stat.reply_st = s5ch_pkg::ST_DONE;
		end
	end

	// Request assembly, one byte per cycle unless a full run waits for output.
	assign total     = {1'b0, name_len_q} + 9'd7;
	assign lane      = pos_q[2:0];
	assign last_byte = (pos_q == total - 9'd1);
	assign word_done = (lane == 3'd7) || last_byte;
	assign advance   = cmd.emit_run && (!word_done || stat.out_free);
	assign push      = cmd.emit_run && word_done && stat.out_free;
	assign nm_idx    = pos_q - 9'd5;
	assign nm_ok     = (nm_idx < DEPTH9);

	always_comb begin
		if (cmd.start_emit) begin
			pos_nx = '0;
		end else if (advance) begin
			pos_nx = pos_q + 9'd1;
		end else begin
			pos_nx = pos_q;
		end
	end

	// The read address always targets the name byte needed in the next cycle.
	assign nm_nx    = pos_nx - 9'd5;
	assign store_en = cmd.store_wr && ({1'b0, name_index} < DEPTH9);

	s5ch_ram #(
		.WIDTH(8),
		.DEPTH(NAME_DEPTH)
	) u_name_ram (
		.clk     (clk),
		.we      (store_en),
		.wr_addr (name_index[AW-1:0]),
		.wr_data (data_byte),
		.rd_addr (nm_nx[AW-1:0]),
		.rd_data (rd_data)
	);

	always_comb begin
		case (pos_q)
			9'd0:    tx_b = s5ch_pkg::SOCKS_VER;
			9'd1:    tx_b = s5ch_pkg::CMD_CONNECT;
			9'd2:    tx_b = s5ch_pkg::RSV_BYTE;
			9'd3:    tx_b = s5ch_pkg::ATYP_DOMAIN;
			9'd4:    tx_b = name_len_q;
			default: begin
				if (pos_q == total - 9'd2) begin
					tx_b = remote_port_q[15:8];
				end else if (last_byte) begin
					tx_b = remote_port_q[7:0];
				end else begin
					tx_b = nm_ok ? rd_data : 8'h00;
				end
			end
		endcase
	end

	always_comb begin
		word = acc_q;
		word[{lane, 3'b000} +: 8] = tx_b;
	end

	always_ff @(posedge clk) begin
		if (cmd.start_emit) begin
			acc_q <= '0;
		end else if (push) begin
			acc_q <= '0;
		end else if (advance) begin
			acc_q <= word;
		end
		pos_q <= pos_nx;
	end

	assign stat.word_done = word_done;
	assign stat.msg_last  = last_byte;
	assign stat.out_free  = !out_valid_q || out_ready;

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			tx_bytes_q  <= '0;
			tx_count_q  <= '0;
			status_q    <= '0;
			run_last_q  <= 1'b0;
		end else if (cmd.load_greet) begin
			out_valid_q <= 1'b1;
			tx_bytes_q  <= {40'd0, s5ch_pkg::RSV_BYTE, s5ch_pkg::NMETHODS_ONE,
			                s5ch_pkg::SOCKS_VER};
			tx_count_q  <= 4'd3;
			status_q    <= s5ch_pkg::ST_NEED;
			run_last_q  <= 1'b1;
		end else if (cmd.load_status) begin
			out_valid_q <= 1'b1;
			tx_bytes_q  <= '0;
			tx_count_q  <= '0;
			status_q    <= cmd.load_st;
			run_last_q  <= 1'b1;
		end else if (push) begin
			out_valid_q <= 1'b1;
			tx_bytes_q  <= word;
			tx_count_q  <= {1'b0, lane} + 4'd1;
			status_q    <= s5ch_pkg::ST_NEED;
			run_last_q  <= last_byte;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign tx_bytes  = tx_bytes_q;
	assign tx_count  = tx_count_q;
	assign status    = status_q;
	assign run_last  = run_last_q;

endmodule

FILE: hdl/s5ch_ctrl.sv
// Controller of the SOCKS5 client handshake unit: protocol phase, input
// acceptance and sequencing of the request emission. Depends on s5ch_pkg.
module s5ch_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         kind,
	input  logic               packet_end,
	input  s5ch_pkg::dp_stat_t stat,
	output s5ch_pkg::dp_cmd_t  cmd
);

	typedef enum logic {
		S_IDLE,
		S_EMIT
	} state_t;

	typedef enum logic [1:0] {
		PH_GREET,
		PH_METHOD,
		PH_REPLY,
		PH_DONE
	} phase_t;

	state_t state_q, state_nx;
	phase_t phase_q, phase_nx;
	logic   accept, pkt_close;

	assign in_ready = (state_q == S_IDLE) && stat.out_free;
	assign accept   = in_valid && in_ready;
	assign pkt_close = accept && ((kind == s5ch_pkg::KIND_EMPTY) ||
	                              ((kind == s5ch_pkg::KIND_BYTE) && packet_end));

	always_comb begin
		cmd       = '0;
		state_nx  = state_q;
		phase_nx  = phase_q;
		cmd.take_byte = accept && (kind == s5ch_pkg::KIND_BYTE);
		cmd.store_wr  = accept && (kind == s5ch_pkg::KIND_NAME);
		cmd.clear_pkt = pkt_close;
		cmd.emit_run  = (state_q == S_EMIT);
		if (pkt_close) begin
			case (phase_q)
				PH_GREET: begin
					cmd.load_greet = 1'b1;
					phase_nx = PH_METHOD;
				end
				PH_METHOD: begin
					if (stat.meth_st == s5ch_pkg::ST_NEED) begin
						cmd.start_emit = 1'b1;
						phase_nx = PH_REPLY;
						state_nx = S_EMIT;
					end else begin
						cmd.load_status = 1'b1;
						cmd.load_st     = stat.meth_st;
					end
				end
				PH_REPLY: begin
					cmd.load_status = 1'b1;
					cmd.load_st     = stat.reply_st;
					if (stat.reply_st == s5ch_pkg::ST_DONE) begin
						phase_nx = PH_DONE;
					end
				end
				default: begin
					cmd.load_status = 1'b1;
					cmd.load_st     = s5ch_pkg::ST_DONE;
				end
			endcase
		end
		if ((state_q == S_EMIT) && stat.word_done && stat.msg_last && stat.out_free) begin
			state_nx = S_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			phase_q <= PH_GREET;
		end else begin
			state_q <= state_nx;
			phase_q <= phase_nx;
		end
	end

endmodule

FILE: sim/tb_socks5_client_handshake_unit.sv
// Self-checking testbench for socks5_client_handshake_unit: drives byte, empty-packet
// and name-store transactions, predicts every result and checks it field by field.
// Depends on s5ch_pkg and the RTL under hdl/ only.
module tb_socks5_client_handshake_unit;
	timeunit 1ns;
	timeprecision 1ps;

	// Kind code 3 is not used by the block; it must be ignored.
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	// Settling time after the last expected result before a register write or
	// the final verdict. Covers name writes still in flight and the output stage.
	localparam int SETTLE_CYCLES = 16;
	// The limit lies well above the slowest legal run.
	localparam int CYCLE_LIMIT = 300000;

	// Negotiation phases of the handshake, as tracked by the predictor.
	typedef enum logic [1:0] {
		PH_GREETING,
		PH_METHOD,
		PH_REPLY,
		PH_DONE
	} hs_phase_t;

	// One input transaction, as queued for the driver.
	typedef struct {
		logic [1:0] kind;
		logic [7:0] data;
		logic       pend;
		logic [7:0] nidx;
	} in_item_t;

	// One result transaction, as predicted.
	typedef struct {
		logic [63:0] bytes;
		logic [3:0]  count;
		logic [2:0]  st;
		logic        last;
	} tx_result_t;

	// Clock, reset and all block inputs start at known values.
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_index = 1'b0;
	logic [15:0] cfg_data = 16'd0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  kind = 2'd0;
	logic [7:0]  data_byte = 8'd0;
	logic        packet_end = 1'b0;
	logic [7:0]  name_index = 8'd0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [63:0] tx_bytes;
	logic [3:0]  tx_count;
	logic [2:0]  status;
	logic        run_last;

	socks5_client_handshake_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.data_byte(data_byte),
		.packet_end(packet_end),
		.name_index(name_index),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.tx_bytes(tx_bytes),
		.tx_count(tx_count),
		.status(status),
		.run_last(run_last)
	);

	// Transactions waiting to be driven, and results waiting to be observed.
	in_item_t   outbound_items[$];
	tx_result_t awaited_results[$];

	// Bookkeeping shared between the stimulus, the driver and the monitor.
	int items_queued = 0;
	int items_taken = 0;
	int phase_items = 0;
	int results_seen = 0;
	int mismatch_count = 0;
	int cycle_count = 0;

	// Predictor copy of the block: configuration, negotiation phase, packet
	// capture and the name store. Reset is applied only once, so the initial
	// values here match the state right after reset.
	logic [15:0] port_cfg = 16'd0;
	logic [7:0]  name_len_cfg = 8'd0;
	hs_phase_t   phase = PH_GREETING;
	logic [3:0]  pkt_len = 4'd0;
	logic [7:0]  first_byte = 8'd0;
	logic [7:0]  second_byte = 8'd0;
	logic [7:0]  addr_type = 8'd0;
	logic        addr_nonzero = 1'b0;
	logic [7:0]  name_mem [0:255];

	// Stimulus side: which name store entries hold a value, and a scratch packet.
	bit          name_loaded [0:255];
	logic [7:0]  pkt_bytes[$];

	// Driver and monitor pacing state.
	in_item_t    cur_item;
	int          send_gap = 0;
	int          send_calm = 0;
	int          send_roll;
	int          stall_left = 0;
	int          ready_calm = 0;
	int          hold_left = 0;
	int          ready_roll;
	tx_result_t  seen_exp;

	initial begin
		forever #5 clk = ~clk;
	end

	// Watchdog: a run that hangs waiting for a result ends here as a failure.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	//------------------------------------------------------------------------
	// Predictor
	//------------------------------------------------------------------------

	task automatic await_result(input logic [63:0] bytes, input logic [3:0] count,
			input logic [2:0] st, input logic last);
		tx_result_t r;
		r.bytes = bytes;
		r.count = count;
		r.st = st;
		r.last = last;
		awaited_results.push_back(r);
	endtask

	// The CONNECT request: version, command, reserved, domain address type, the
	// name length, the name bytes and the port high byte first. It leaves the
	// block in runs of up to eight bytes, lowest lane first, with unused lanes
	// zero and only the final run marked last.
	task automatic queue_connect_request();
		logic [7:0]  msg [0:261];
		logic [63:0] word;
		int          total;
		int          i;
		int          j;
		int          cnt;
		msg[0] = s5ch_pkg::SOCKS_VER;
		msg[1] = s5ch_pkg::CMD_CONNECT;
		msg[2] = s5ch_pkg::RSV_BYTE;
		msg[3] = s5ch_pkg::ATYP_DOMAIN;
		msg[4] = name_len_cfg;
		for (i = 0; i < name_len_cfg; i++)
			msg[5 + i] = name_mem[i];
		msg[5 + name_len_cfg] = port_cfg[15:8];
		msg[6 + name_len_cfg] = port_cfg[7:0];
		total = 7 + name_len_cfg;
		for (i = 0; i < total; i += 8) begin
			cnt = (total - i < 8) ? (total - i) : 8;
			word = 64'd0;
			for (j = 0; j < cnt; j++)
				word[8 * j +: 8] = msg[i + j];
			await_result(word, cnt[3:0], s5ch_pkg::ST_NEED, (i + 8 >= total));
		end
	endtask

	// End of a packet: advance the negotiation. Errors keep the phase as is.
	task automatic close_packet();
		logic [2:0] st;
		st = s5ch_pkg::ST_DONE;
		case (phase)
			PH_GREETING: begin
				// Any packet at all triggers the greeting 05 01 00.
				await_result({40'd0, s5ch_pkg::METHOD_NONE, s5ch_pkg::NMETHODS_ONE,
					s5ch_pkg::SOCKS_VER}, 4'd3, s5ch_pkg::ST_NEED, 1'b1);
				phase = PH_METHOD;
			end
			PH_METHOD: begin
				if (pkt_len != 4'd2 || first_byte != s5ch_pkg::SOCKS_VER)
					st = s5ch_pkg::ST_UNEXPECTED;
				else if (second_byte == s5ch_pkg::METHOD_REJECT)
					st = s5ch_pkg::ST_AUTH;
				else if (second_byte != s5ch_pkg::METHOD_NONE)
					st = s5ch_pkg::ST_UNEXPECTED;
				else
					st = s5ch_pkg::ST_NEED;
				if (st == s5ch_pkg::ST_NEED) begin
					queue_connect_request();
					phase = PH_REPLY;
				end else begin
					await_result(64'd0, 4'd0, st, 1'b1);
				end
			end
			PH_REPLY: begin
				// The version byte of the reply is deliberately not checked, and
				// an address type the block does not know counts as success.
				if (pkt_len < 4'd4)
					st = s5ch_pkg::ST_UNEXPECTED;
				else if (second_byte != s5ch_pkg::REPLY_OK)
					st = s5ch_pkg::ST_CONNECT;
				else if (addr_type == s5ch_pkg::ATYP_IPV4)
					st = (pkt_len != 4'd10 || addr_nonzero) ? s5ch_pkg::ST_UNEXPECTED
					                                        : s5ch_pkg::ST_DONE;
				else if (addr_type == s5ch_pkg::ATYP_DOMAIN ||
				         addr_type == s5ch_pkg::ATYP_IPV6)
					st = s5ch_pkg::ST_UNEXPECTED;
				if (st == s5ch_pkg::ST_DONE)
					phase = PH_DONE;
				await_result(64'd0, 4'd0, st, 1'b1);
			end
			default: begin
				await_result(64'd0, 4'd0, s5ch_pkg::ST_DONE, 1'b1);
			end
		endcase
		pkt_len = 4'd0;
		first_byte = 8'd0;
		second_byte = 8'd0;
		addr_type = 8'd0;
		addr_nonzero = 1'b0;
	endtask

	// Apply one accepted input transaction to the predictor.
	task automatic absorb_transaction(input in_item_t it);
		if (it.kind == s5ch_pkg::KIND_NAME) begin
			name_mem[it.nidx] = it.data;
		end else if (it.kind == s5ch_pkg::KIND_BYTE || it.kind == s5ch_pkg::KIND_EMPTY) begin
			if (it.kind == s5ch_pkg::KIND_BYTE) begin
				// Only bytes 0, 1, 3 and the address bytes 4 to 9 are kept;
				// longer packets are only counted, saturating at 15.
				case (pkt_len)
					4'd0: first_byte = it.data;
					4'd1: second_byte = it.data;
					4'd3: addr_type = it.data;
					4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9: begin
						if (it.data != 8'd0)
							addr_nonzero = 1'b1;
					end
					default: ;
				endcase
				if (pkt_len != s5ch_pkg::PKT_LEN_MAX)
					pkt_len = pkt_len + 4'd1;
			end
			// An empty transaction closes whatever is pending, even nothing.
			if (it.kind == s5ch_pkg::KIND_EMPTY || it.pend)
				close_packet();
		end
	endtask

	//------------------------------------------------------------------------
	// Driver: one transaction at a time from outbound_items, valid held until
	// accepted, random gaps between transactions with occasional calm stretches.
	//------------------------------------------------------------------------

	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				absorb_transaction(cur_item);
				items_taken++;
			end
			if (!in_valid || in_ready) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (outbound_items.size() != 0) begin
					cur_item = outbound_items.pop_front();
					kind <= cur_item.kind;
					data_byte <= cur_item.data;
					packet_end <= cur_item.pend;
					name_index <= cur_item.nidx;
					in_valid <= 1'b1;
					// Gap after this transaction: mostly none, some short, a few long.
					if (send_calm > 0) begin
						send_calm--;
					end else begin
						send_roll = $urandom_range(0, 99);
						if (send_roll < 22)
							send_gap = $urandom_range(1, 3);
						else if (send_roll < 27)
							send_gap = $urandom_range(8, 30);
						else if (send_roll < 30)
							send_calm = $urandom_range(30, 100);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	//------------------------------------------------------------------------
	// Monitor: checks each result against the oldest prediction and paces
	// out_ready. Every twentieth result or so it holds off for a long stretch
	// so the output stage fills and the block stops taking input.
	//------------------------------------------------------------------------

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		mismatch_count++;
		$display("mismatch on result %0d: %s got %h expected %h",
			results_seen, what, got, want);
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (awaited_results.size() == 0) begin
					report_mismatch("unexpected result, tx_bytes", tx_bytes, 64'd0);
				end else begin
					seen_exp = awaited_results.pop_front();
					if (tx_bytes !== seen_exp.bytes)
						report_mismatch("tx_bytes", tx_bytes, seen_exp.bytes);
					if (tx_count !== seen_exp.count)
						report_mismatch("tx_count", 64'(tx_count), 64'(seen_exp.count));
					if (status !== seen_exp.st)
						report_mismatch("status", 64'(status), 64'(seen_exp.st));
					if (run_last !== seen_exp.last)
						report_mismatch("run_last", 64'(run_last), 64'(seen_exp.last));
				end
				results_seen++;
				if (results_seen % 20 == 3)
					hold_left = $urandom_range(60, 90);
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if (ready_calm > 0) begin
					ready_calm--;
				end else begin
					ready_roll = $urandom_range(0, 99);
					if (ready_roll < 20)
						stall_left = $urandom_range(1, 3);
					else if (ready_roll < 23)
						stall_left = $urandom_range(10, 40);
					else if (ready_roll < 26)
						ready_calm = $urandom_range(40, 120);
				end
			end
		end
	end

	//------------------------------------------------------------------------
	// Stimulus helpers
	//------------------------------------------------------------------------

	function automatic logic [7:0] rand_byte();
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic push_item(input logic [1:0] k, input logic [7:0] d, input logic e,
			input logic [7:0] idx);
		in_item_t it;
		it.kind = k;
		it.data = d;
		it.pend = e;
		it.nidx = idx;
		outbound_items.push_back(it);
		items_queued++;
		// Ignored transactions do not count toward the phase size.
		if (k != KIND_UNUSED)
			phase_items++;
		if (k == s5ch_pkg::KIND_NAME)
			name_loaded[idx] = 1'b1;
	endtask

	// Ignored kinds and name writes are sprinkled inside packets; neither of
	// them may disturb the packet being gathered.
	task automatic maybe_noise();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 4)
			push_item(KIND_UNUSED, rand_byte(), 1'($urandom_range(0, 1)), rand_byte());
		else if (roll < 8)
			push_item(s5ch_pkg::KIND_NAME, rand_byte(), 1'($urandom_range(0, 1)),
				rand_byte());
	endtask

	// Send pkt_bytes as one packet. It is closed either by the end mark on the
	// last byte or by a trailing empty transaction; an empty packet is always
	// a lone empty transaction.
	task automatic send_packet(input bit close_empty);
		int i;
		for (i = 0; i < pkt_bytes.size(); i++) begin
			maybe_noise();
			push_item(s5ch_pkg::KIND_BYTE, pkt_bytes[i],
				!close_empty && (i == pkt_bytes.size() - 1), rand_byte());
		end
		if (close_empty || pkt_bytes.size() == 0)
			push_item(s5ch_pkg::KIND_EMPTY, rand_byte(), 1'($urandom_range(0, 1)),
				rand_byte());
	endtask

	// Method replies that must not start the request.
	task automatic build_bad_method();
		logic [7:0] b;
		int         n;
		int         i;
		pkt_bytes.delete();
		case ($urandom_range(0, 5))
			0: ;
			1: pkt_bytes.push_back(rand_byte());
			2: begin
				// Wrong length, sometimes long enough to saturate the counter.
				n = $urandom_range(3, 17);
				for (i = 0; i < n; i++)
					pkt_bytes.push_back(($urandom_range(0, 2) == 0) ? s5ch_pkg::SOCKS_VER
					                                                : rand_byte());
			end
			3: begin
				b = rand_byte();
				if (b == s5ch_pkg::SOCKS_VER)
					b = b ^ 8'h80;
				pkt_bytes.push_back(b);
				pkt_bytes.push_back(($urandom_range(0, 1) == 0) ? s5ch_pkg::METHOD_NONE
				                                                : rand_byte());
			end
			4: pkt_bytes = '{s5ch_pkg::SOCKS_VER, s5ch_pkg::METHOD_REJECT};
			default: begin
				b = 8'($urandom_range(1, 254));
				pkt_bytes = '{s5ch_pkg::SOCKS_VER, b};
			end
		endcase
	endtask

	// First four bytes of a connect reply with a good reply code.
	task automatic reply_head(input logic [7:0] atyp);
		pkt_bytes.delete();
		pkt_bytes.push_back(($urandom_range(0, 1) == 0) ? s5ch_pkg::SOCKS_VER : rand_byte());
		pkt_bytes.push_back(s5ch_pkg::REPLY_OK);
		pkt_bytes.push_back(rand_byte());
		pkt_bytes.push_back(atyp);
	endtask

	// Connect replies that must fail and keep the reply phase.
	task automatic build_bad_reply();
		logic [7:0] b;
		int         n;
		int         i;
		pkt_bytes.delete();
		case ($urandom_range(0, 4))
			0: begin
				n = $urandom_range(0, 3);
				for (i = 0; i < n; i++)
					pkt_bytes.push_back(rand_byte());
			end
			1: begin
				// Refused by the server: nonzero reply code.
				n = $urandom_range(4, 14);
				for (i = 0; i < n; i++)
					pkt_bytes.push_back(rand_byte());
				b = rand_byte();
				if (b == s5ch_pkg::REPLY_OK)
					b = b + 8'd1;
				pkt_bytes[1] = b;
			end
			2: begin
				// IPv4 reply of the wrong length, address all zero.
				n = $urandom_range(4, 16);
				if (n >= 10)
					n++;
				reply_head(s5ch_pkg::ATYP_IPV4);
				for (i = 4; i < n; i++)
					pkt_bytes.push_back((i <= 9) ? 8'd0 : rand_byte());
			end
			3: begin
				// IPv4 reply of the right length with a nonzero bound address.
				reply_head(s5ch_pkg::ATYP_IPV4);
				for (i = 4; i < 10; i++)
					pkt_bytes.push_back(($urandom_range(0, 1) == 0) ? 8'd0 : rand_byte());
				b = 8'($urandom_range(1, 255));
				pkt_bytes[$urandom_range(4, 9)] = b;
			end
			default: begin
				reply_head(($urandom_range(0, 1) == 0) ? s5ch_pkg::ATYP_DOMAIN
				                                       : s5ch_pkg::ATYP_IPV6);
				n = $urandom_range(4, 14);
				for (i = 4; i < n; i++)
					pkt_bytes.push_back(rand_byte());
			end
		endcase
	endtask

	// A connect reply that finishes the negotiation.
	task automatic build_good_reply();
		logic [7:0] b;
		int         n;
		int         i;
		if ($urandom_range(0, 1) == 0) begin
			reply_head(s5ch_pkg::ATYP_IPV4);
			for (i = 0; i < 6; i++)
				pkt_bytes.push_back(8'd0);
		end else begin
			// Unknown address types are let through by the block.
			b = rand_byte();
			while (b == s5ch_pkg::ATYP_IPV4 || b == s5ch_pkg::ATYP_DOMAIN ||
			       b == s5ch_pkg::ATYP_IPV6)
				b = rand_byte();
			reply_head(b);
			n = $urandom_range(4, 17);
			for (i = 4; i < n; i++)
				pkt_bytes.push_back(rand_byte());
		end
	endtask

	// Wait until every queued transaction is taken and every predicted result
	// has arrived, then let the block settle.
	task automatic wait_quiet();
		while (items_taken != items_queued || awaited_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Both registers, written back to back while the block is idle.
	task automatic write_regs(input logic [15:0] port, input logic [7:0] len);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= s5ch_pkg::REG_REMOTE_PORT;
		cfg_data <= port;
		@(posedge clk);
		cfg_index <= s5ch_pkg::REG_NAME_LENGTH;
		cfg_data <= {8'd0, len};
		@(posedge clk);
		cfg_we <= 1'b0;
		port_cfg = port;
		name_len_cfg = len;
	endtask

	//------------------------------------------------------------------------
	// Test sequence. The negotiation only moves forward and reset is applied
	// once, so the run walks through it a single time: greeting, a long stay
	// in the method phase, one request, a long stay in the reply phase, then
	// success and a tail in the done phase.
	//------------------------------------------------------------------------

	initial begin : main_seq
		logic [15:0] req_port;
		logic [7:0]  req_len;
		int          i;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Lowest register values first.
		write_regs(16'h0000, 8'h00);

		// Directed part. An ignored kind, name writes at both ends of the
		// store, then a packet closed by an empty transaction with bytes
		// pending, which draws the greeting.
		push_item(KIND_UNUSED, 8'hA5, 1'b1, 8'h5A);
		push_item(s5ch_pkg::KIND_NAME, 8'h00, 1'b0, 8'h00);
		push_item(s5ch_pkg::KIND_NAME, 8'hFF, 1'b1, 8'hFF);
		push_item(s5ch_pkg::KIND_BYTE, 8'hFF, 1'b0, 8'h00);
		push_item(s5ch_pkg::KIND_BYTE, 8'h00, 1'b0, 8'hFF);
		push_item(s5ch_pkg::KIND_EMPTY, 8'hFF, 1'b1, 8'h00);
		// Method phase errors: empty packet, bad version, rejected method,
		// unsupported method, wrong length.
		push_item(s5ch_pkg::KIND_EMPTY, 8'h00, 1'b0, 8'hFF);
		pkt_bytes = '{8'h04, s5ch_pkg::METHOD_NONE};
		send_packet(1'b0);
		pkt_bytes = '{s5ch_pkg::SOCKS_VER, s5ch_pkg::METHOD_REJECT};
		send_packet(1'b1);
		pkt_bytes = '{s5ch_pkg::SOCKS_VER, 8'h01};
		send_packet(1'b0);
		pkt_bytes = '{s5ch_pkg::SOCKS_VER, s5ch_pkg::METHOD_NONE, s5ch_pkg::RSV_BYTE};
		send_packet(1'b0);
		wait_quiet();

		// Highest register values while the method phase is hammered with
		// replies that must not start the request.
		write_regs(16'hFFFF, 8'hFF);
		phase_items = 0;
		while (phase_items < 45) begin
			build_bad_method();
			send_packet($urandom_range(0, 3) == 0);
		end
		wait_quiet();

		// Setting used for the request. The name store is filled up to the
		// name length first so the request never reads an empty entry.
		case ($urandom_range(0, 5))
			0: req_len = 8'd0;
			1: req_len = 8'd1;
			2: req_len = 8'd9;
			3: req_len = 8'd255;
			default: req_len = 8'($urandom_range(2, 40));
		endcase
		case ($urandom_range(0, 3))
			0: req_port = 16'h0000;
			1: req_port = 16'hFFFF;
			default: req_port = 16'($urandom_range(0, 65535));
		endcase
		write_regs(req_port, req_len);
		phase_items = 0;
		for (i = 0; i < req_len; i++)
			if (!name_loaded[i])
				push_item(s5ch_pkg::KIND_NAME, rand_byte(), 1'($urandom_range(0, 1)), 8'(i));
		while (phase_items < 25 + req_len) begin
			build_bad_method();
			send_packet($urandom_range(0, 3) == 0);
		end
		pkt_bytes = '{s5ch_pkg::SOCKS_VER, s5ch_pkg::METHOD_NONE};
		send_packet($urandom_range(0, 3) == 0);
		wait_quiet();

		// New register values once the request is out; they must not matter
		// any more. Then the reply phase gets only failing replies.
		write_regs(16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
		phase_items = 0;
		while (phase_items < 110) begin
			build_bad_reply();
			send_packet($urandom_range(0, 3) == 0);
		end
		wait_quiet();

		// Success, then random packets that all answer done.
		phase_items = 0;
		build_good_reply();
		send_packet($urandom_range(0, 3) == 0);
		while (phase_items < 25) begin
			pkt_bytes.delete();
			for (i = $urandom_range(0, 12); i > 0; i--)
				pkt_bytes.push_back(rand_byte());
			send_packet($urandom_range(0, 3) == 0);
		end
		wait_quiet();

		if (mismatch_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

FILE: filelist.f
hdl/s5ch_pkg.sv
hdl/s5ch_ram.sv
hdl/s5ch_datapath.sv
hdl/s5ch_ctrl.sv
hdl/socks5_client_handshake_unit.sv
sim/tb_socks5_client_handshake_unit.sv
